>>> rtl/pdfm_pkg.sv
// pdfm_pkg: widths, constants and control structs of the pwm duty/frequency meter
// used by every rtl file of the block, depends on nothing
package pdfm_pkg;

  localparam int COUNT_BITS = 24;
  localparam int DUTY_W     = 7;
  localparam int FREQ_W     = 26;
  localparam int RATE_W     = 27;
  localparam int ADDR_W     = 3;
  localparam int DATA_W     = 32;

  // period is the sum of two counts
  localparam int PER_W  = COUNT_BITS + 1;
  // high count times one hundred
  localparam int PROD_W = COUNT_BITS + 7;
  // dividend covers both the scaled high count and the tick rate
  localparam int DIVD_W = (PROD_W > RATE_W) ? PROD_W : RATE_W;
  localparam int DIVC_W = $clog2(DIVD_W + 1);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX  = {COUNT_BITS{1'b1}};
  localparam logic [PROD_W-1:0]     DUTY_SCALE = PROD_W'(100);
  localparam logic [RATE_W-1:0]     RATE_RESET = RATE_W'(1000000);

  // register index, taken from the byte address
  localparam logic REG_TICK_RATE = 1'b0;

  typedef struct packed {
    logic take;       // an item is accepted
    logic start_run;  // rising edge opens a measurement
    logic hold_high;  // falling edge ends the high run
    logic bump;       // one more tick in the current run
    logic close;      // rising edge ends the period, start duty division
    logic div_freq;   // keep duty, start frequency division
    logic load_out;   // move the finished result into the output register
  } pdfm_cmd_t;

  typedef struct packed {
    logic rise;
    logic fall;
    logic div_busy;
  } pdfm_stat_t;

endpackage

>>> rtl/pdfm_if.sv
// pdfm_if: valid/ready channels of the pwm duty/frequency meter
// depends on pdfm_pkg for the field widths
interface pdfm_in_if;
  import pdfm_pkg::*;
  logic valid;
  logic ready;
  logic level;
  modport source (output valid, output level, input ready);
  modport sink (input valid, input level, output ready);
endinterface

interface pdfm_out_if;
  import pdfm_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [COUNT_BITS-1:0] high_ticks;
  logic [COUNT_BITS-1:0] low_ticks;
  logic [DUTY_W-1:0]     duty_percent;
  logic [FREQ_W-1:0]     frequency_hz;
  logic                  saturated;
  modport source (output valid, output high_ticks, output low_ticks, output duty_percent,
                  output frequency_hz, output saturated, input ready);
  modport sink (input valid, input high_ticks, input low_ticks, input duty_percent,
                input frequency_hz, input saturated, output ready);
endinterface

>>> rtl/pwm_duty_frequency_meter_unit.sv
// pwm_duty_frequency_meter_unit: top level of the pwm duty/frequency meter
// depends on pdfm_pkg, pdfm_if, pdfm_ctrl, pdfm_datapath and pdfm_div
//
//  channel   dir  handshake       payload
//  samples   in   valid/ready     level
//  results   out  valid/ready     high_ticks, low_ticks, duty_percent, frequency_hz, saturated
//  apb       in   psel/penable    tick_rate_hz at byte address 0
//
// a sample that does not close a period is taken as soon as it is offered
// the sample that closes a period holds the input until both divisions are done and the
// output register is free: one shared divider makes one quotient bit per cycle,
// first for duty, then for frequency
// the result waits in an output register, so counting goes on while it is stalled
// rst is synchronous; no clearing pass is needed
module pwm_duty_frequency_meter_unit
  import pdfm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  pdfm_in_if.sink           samples,
  pdfm_out_if.source        results,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [RATE_W-1:0] tick_rate;
  logic              reg_index;
  logic              cfg_write;
  pdfm_cmd_t         cmd;
  pdfm_stat_t        stat;

  // configuration register, written in the apb access phase
  assign pready    = 1'b1;
  assign reg_index = paddr[2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_rate <= RATE_RESET;
    end else if (cfg_write && (reg_index == REG_TICK_RATE)) begin
      tick_rate <= pwdata[RATE_W-1:0];
    end
  end

  // readback of the tick rate, zero for addresses past the register list
  always_comb begin
    if (reg_index == REG_TICK_RATE) begin
      prdata = DATA_W'(tick_rate);
    end else begin
      prdata = '0;
    end
  end

  // phase tracking and division sequencing
  pdfm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // counters, shared divider and result register
  pdfm_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .level     (samples.level),
    .tick_rate (tick_rate),
    .res_high  (results.high_ticks),
    .res_low   (results.low_ticks),
    .res_duty  (results.duty_percent),
    .res_freq  (results.frequency_hz),
    .res_sat   (results.saturated)
  );

endmodule

>>> rtl/pdfm_div.sv
// pdfm_div: restoring divider, one quotient bit per cycle
// depends on pdfm_pkg for the dividend and period widths
module pdfm_div
  import pdfm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIVD_W-1:0] dividend,
  input  logic [PER_W-1:0]  divisor,
  output logic              busy,
  output logic [DIVD_W-1:0] quotient
);

  logic [PER_W-1:0]  rem;
  logic [PER_W-1:0]  dvs;
  logic [DIVC_W-1:0] cnt;
  logic [PER_W:0]    shifted;
  logic              fits;

  // remainder stays below the divisor, so the shifted value fits one more bit
  assign shifted = {rem, quotient[DIVD_W-1]};
  assign fits    = (shifted >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= DIVC_W'(DIVD_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == DIVC_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (busy) begin
      quotient <= {quotient[DIVD_W-2:0], fits};
      if (fits) begin
        rem <= PER_W'(shifted - {1'b0, dvs});
      end else begin
        rem <= shifted[PER_W-1:0];
      end
    end
  end

endmodule

>>> rtl/pdfm_ctrl.sv
// pdfm_ctrl: measurement phase and division sequencing
// depends on pdfm_pkg for the command and status structs
module pdfm_ctrl
  import pdfm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  pdfm_stat_t stat,
  output pdfm_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_WAIT,
    S_HIGH,
    S_LOW,
    S_DIV_DUTY,
    S_DIV_FREQ
  } state_t;

  state_t state;
  state_t state_next;
  logic   take;
  logic   out_free;

  assign in_ready = (state == S_WAIT) || (state == S_HIGH) || (state == S_LOW);
  assign take     = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd        = '0;
    cmd.take   = take;
    state_next = state;
    unique case (state)
      S_WAIT: begin
        if (take && stat.rise) begin
          cmd.start_run = 1'b1;
          state_next    = S_HIGH;
        end
      end
      S_HIGH: begin
        if (take) begin
          if (stat.fall) begin
            cmd.hold_high = 1'b1;
            state_next    = S_LOW;
          end else begin
            cmd.bump = 1'b1;
          end
        end
      end
      S_LOW: begin
        if (take) begin
          if (stat.rise) begin
            cmd.close  = 1'b1;
            state_next = S_DIV_DUTY;
          end else begin
            cmd.bump = 1'b1;
          end
        end
      end
      S_DIV_DUTY: begin
        if (!stat.div_busy) begin
          cmd.div_freq = 1'b1;
          state_next   = S_DIV_FREQ;
        end
      end
      S_DIV_FREQ: begin
        if (!stat.div_busy && out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_WAIT;
        end
      end
      default: begin
        state_next = S_WAIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_WAIT;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/pdfm_datapath.sv
// pdfm_datapath: tick counters, division operands and result register
// depends on pdfm_pkg and instantiates pdfm_div
module pdfm_datapath
  import pdfm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  pdfm_cmd_t             cmd,
  output pdfm_stat_t            stat,
  input  logic                  level,
  input  logic [RATE_W-1:0]     tick_rate,
  output logic [COUNT_BITS-1:0] res_high,
  output logic [COUNT_BITS-1:0] res_low,
  output logic [DUTY_W-1:0]     res_duty,
  output logic [FREQ_W-1:0]     res_freq,
  output logic                  res_sat
);

  logic                  last_level;
  logic [COUNT_BITS-1:0] run_count;
  logic [COUNT_BITS-1:0] held_high;
  logic                  sat_seen;

  logic [COUNT_BITS-1:0] op_hi;
  logic [COUNT_BITS-1:0] op_lo;
  logic                  op_sat;
  logic [PER_W-1:0]      period;
  logic [DUTY_W-1:0]     duty_q;

  logic [PER_W-1:0]      period_now;
  logic [PROD_W-1:0]     duty_num;
  logic                  div_start;
  logic [DIVD_W-1:0]     div_dividend;
  logic [PER_W-1:0]      div_divisor;
  logic                  div_busy;
  logic [DIVD_W-1:0]     div_quo;

  assign stat.rise     = !last_level && level;
  assign stat.fall     = last_level && !level;
  assign stat.div_busy = div_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_level <= 1'b0;
      run_count  <= '0;
      held_high  <= '0;
      sat_seen   <= 1'b0;
    end else begin
      if (cmd.take) begin
        last_level <= level;
      end
      if (cmd.start_run) begin
        run_count <= COUNT_BITS'(1);
        held_high <= '0;
        sat_seen  <= 1'b0;
      end
      if (cmd.hold_high) begin
        held_high <= run_count;
        run_count <= COUNT_BITS'(1);
      end
      if (cmd.bump) begin
        if (run_count == COUNT_MAX) begin
          sat_seen <= 1'b1;
        end else begin
          run_count <= run_count + 1'b1;
        end
      end
      if (cmd.close) begin
        run_count <= '0;
      end
    end
  end

  // division operands; tick rate read at div_freq, the rest at close
  assign period_now = {1'b0, held_high} + {1'b0, run_count};
  assign duty_num   = PROD_W'(held_high) * DUTY_SCALE;

  assign div_start    = cmd.close || cmd.div_freq;
  assign div_dividend = cmd.close ? DIVD_W'(duty_num) : DIVD_W'(tick_rate);
  assign div_divisor  = cmd.close ? period_now : period;

  always_ff @(posedge clk) begin
    if (cmd.close) begin
      op_hi  <= held_high;
      op_lo  <= run_count;
      op_sat <= sat_seen;
      period <= period_now;
    end
    if (cmd.div_freq) begin
      duty_q <= div_quo[DUTY_W-1:0];
    end
    if (cmd.load_out) begin
      res_high <= op_hi;
      res_low  <= op_lo;
      res_duty <= duty_q;
      res_freq <= div_quo[FREQ_W-1:0];
      res_sat  <= op_sat;
    end
  end

  pdfm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (div_quo)
  );

endmodule

>>> tb/sv/pdfm_period_checker.sv
// pdfm_period_checker: watches the sample, result and apb ports of the pwm meter,
// predicts each measured period and compares it field by field
// depends on pdfm_pkg and the channel interfaces in pdfm_if
module pdfm_period_checker
  import pdfm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  pdfm_in_if                samples,
  pdfm_out_if               results,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  input  logic [DATA_W-1:0] prdata,
  input  logic              pready,
  output int                mismatch_count,
  output int                periods_owed,
  output int                periods_predicted
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PRINT_LIMIT = 40;

  typedef enum logic [1:0] {
    WAIT_RISE  = 2'd0,
    COUNT_HIGH = 2'd1,
    COUNT_LOW  = 2'd2
  } meter_phase_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0] high_ticks;
    logic [COUNT_BITS-1:0] low_ticks;
    logic [DUTY_W-1:0]     duty_percent;
    logic [FREQ_W-1:0]     frequency_hz;
    logic                  saturated;
  } period_meas_t;

  meter_phase_t          meter_phase;
  logic                  prev_level;
  logic [COUNT_BITS-1:0] run_ticks;
  logic [COUNT_BITS-1:0] held_high;
  logic                  sat_flag;
  logic [RATE_W-1:0]     tick_rate;
  period_meas_t          expected_periods[$];
  period_meas_t          seen;

  task automatic report_mismatch(input string what, input longint unsigned got_v,
                                 input longint unsigned want_v);
    if (mismatch_count < PRINT_LIMIT)
      $display("mismatch %s: got %0d expected %0d at %0t", what, got_v, want_v, $time);
    mismatch_count++;
  endtask

  // one more tick in the current run, stuck at the top of the count
  task automatic bump_run();
    if (run_ticks == COUNT_MAX) sat_flag = 1'b1;
    else run_ticks = run_ticks + 1'b1;
  endtask

  task automatic measure_level(input logic lv);
    logic              rise;
    logic              fall;
    logic [PER_W-1:0]  span;
    logic [63:0]       duty_full;
    logic [63:0]       freq_full;
    period_meas_t      meas;
    rise = !prev_level && lv;
    fall = prev_level && !lv;
    case (meter_phase)
      COUNT_HIGH: begin
        if (fall) begin
          held_high   = run_ticks;
          run_ticks   = COUNT_BITS'(1);
          meter_phase = COUNT_LOW;
        end else begin
          bump_run();
        end
      end
      COUNT_LOW: begin
        if (rise) begin
          span = PER_W'(held_high) + PER_W'(run_ticks);
          duty_full = '0;
          freq_full = '0;
          if (span != '0) begin
            duty_full = (64'(held_high) * 64'd100) / 64'(span);
            freq_full = 64'(tick_rate) / 64'(span);
          end
          meas.high_ticks   = held_high;
          meas.low_ticks    = run_ticks;
          meas.duty_percent = duty_full[DUTY_W-1:0];
          meas.frequency_hz = freq_full[FREQ_W-1:0];
          meas.saturated    = sat_flag;
          expected_periods.push_back(meas);
          periods_predicted++;
          run_ticks   = '0;
          meter_phase = WAIT_RISE;
        end else begin
          bump_run();
        end
      end
      default: begin
        // the closing edge does not reopen, a fresh rise is needed
        if (rise) begin
          run_ticks   = COUNT_BITS'(1);
          held_high   = '0;
          sat_flag    = 1'b0;
          meter_phase = COUNT_HIGH;
        end else begin
          meter_phase = WAIT_RISE;
        end
      end
    endcase
    prev_level = lv;
  endtask

  task automatic check_period(input period_meas_t got);
    period_meas_t want;
    if (expected_periods.size() == 0) begin
      report_mismatch("result with nothing owed, high_ticks", got.high_ticks, 0);
    end else begin
      want = expected_periods.pop_front();
      if (got.high_ticks !== want.high_ticks)
        report_mismatch("high_ticks", got.high_ticks, want.high_ticks);
      if (got.low_ticks !== want.low_ticks)
        report_mismatch("low_ticks", got.low_ticks, want.low_ticks);
      if (got.duty_percent !== want.duty_percent)
        report_mismatch("duty_percent", got.duty_percent, want.duty_percent);
      if (got.frequency_hz !== want.frequency_hz)
        report_mismatch("frequency_hz", got.frequency_hz, want.frequency_hz);
      if (got.saturated !== want.saturated)
        report_mismatch("saturated", got.saturated, want.saturated);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      meter_phase = WAIT_RISE;
      prev_level  = 1'b0;
      run_ticks   = '0;
      held_high   = '0;
      sat_flag    = 1'b0;
      tick_rate   = RATE_RESET;
      expected_periods.delete();
    end else begin
      // results first: a result never belongs to the sample of the same edge
      if (results.valid && results.ready) begin
        seen.high_ticks   = results.high_ticks;
        seen.low_ticks    = results.low_ticks;
        seen.duty_percent = results.duty_percent;
        seen.frequency_hz = results.frequency_hz;
        seen.saturated    = results.saturated;
        check_period(seen);
      end
      if (samples.valid && samples.ready) measure_level(samples.level);
      if (psel && penable && pready && paddr[ADDR_W-1:2] == REG_TICK_RATE) begin
        if (pwrite) tick_rate = pwdata[RATE_W-1:0];
        else if (prdata !== DATA_W'(tick_rate))
          report_mismatch("tick_rate_hz readback", prdata, tick_rate);
      end
    end
    periods_owed = expected_periods.size();
  end

endmodule

>>> tb/sv/pwm_duty_frequency_meter_unit_tb.sv
// pwm_duty_frequency_meter_unit_tb: drives pwm sample streams and tick-rate settings
// into the meter, the period checker beside it predicts and compares every result
// depends on pdfm_pkg, pdfm_if, pdfm_period_checker and the meter rtl
module pwm_duty_frequency_meter_unit_tb;
  import pdfm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // tick-rate settings, one per random phase
  localparam int N_PHASES       = 8;
  localparam int PHASE_ITEMS    = 190;
  localparam int PHASE_PERIODS  = 8;
  localparam int PRESSURE_PHASE = 3;
  // result hold-off long enough to fill the output register and stall samples
  localparam int HOLD_CYCLES    = 400;
  // a closing sample keeps the divider busy for two divisions; the settle time covers them
  localparam int SETTLE_CYCLES  = 2 * DIVD_W + 16;
  localparam int IDLE_LIMIT     = 4000;

  localparam logic                UNMAPPED_INDEX = 1'b1;
  localparam logic [ADDR_W-1:0]   TICK_RATE_ADDR = {REG_TICK_RATE, 2'b00};
  localparam logic [ADDR_W-1:0]   UNMAPPED_ADDR  = {UNMAPPED_INDEX, 2'b00};
  localparam logic                APB_WRITE      = 1'b1;
  localparam logic                APB_READ       = 1'b0;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  int   mismatch_count;
  int   periods_owed;
  int   periods_predicted;

  // sender bookkeeping
  int   sample_total;
  int   phase_items;
  int   burst_left;
  logic cur_level;
  // set here once, the receiver starts its hold-off when it first sees it
  logic hold_req;

  logic [DATA_W-1:0] rate_plan[N_PHASES];

  pdfm_in_if  samples_ch();
  pdfm_out_if results_ch();

  pwm_duty_frequency_meter_unit dut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples_ch),
    .results (results_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  pdfm_period_checker meter_chk (
    .clk               (clk),
    .rst               (rst),
    .samples           (samples_ch),
    .results           (results_ch),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .mismatch_count    (mismatch_count),
    .periods_owed      (periods_owed),
    .periods_predicted (periods_predicted)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // apb transfer: setup cycle, access cycle, then an idle cycle
  task automatic apb_access(input logic wr, input logic [ADDR_W-1:0] addr,
                            input logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // one sample item; bursts of random length, the short ones with gaps ahead of them
  task automatic push_level(input logic lv);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        // long stretch with no gaps
        burst_left = $urandom_range(80, 250);
      end else begin
        burst_left = $urandom_range(1, 20);
        samples_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
    samples_ch.valid <= 1'b1;
    samples_ch.level <= lv;
    @(posedge clk);
    while (!samples_ch.ready) @(posedge clk);
    cur_level = lv;
    sample_total++;
    phase_items++;
  endtask

  task automatic send_run(input logic lv, input int n);
    repeat (n) push_level(lv);
  endtask

  // mostly short runs, sometimes long ones so the counts grow wide
  function automatic int pick_run_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 3);
    if (r < 90) return $urandom_range(4, 16);
    if (r < 98) return $urandom_range(17, 80);
    return $urandom_range(81, 400);
  endfunction

  // stop offering, wait for every owed period, then let the divider settle
  task automatic drain();
    samples_ch.valid <= 1'b0;
    @(posedge clk);
    while (periods_owed != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // receiver: stall pattern changes per stretch, plus the one long hold-off
  initial begin
    int   stretch_left;
    int   stall_pct;
    int   held;
    logic hold_done;
    results_ch.ready <= 1'b0;
    stretch_left = 0;
    stall_pct    = 0;
    hold_done    = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        results_ch.ready <= 1'b0;
        hold_done = 1'b1;
        for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk);
      end else begin
        if (stretch_left == 0) begin
          stretch_left = $urandom_range(16, 96);
          case ($urandom_range(0, 4))
            0, 1:    stall_pct = 0;
            2:       stall_pct = 30;
            3:       stall_pct = 60;
            default: stall_pct = 90;
          endcase
        end
        stretch_left--;
        results_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // watchdog: too many cycles with no item, result or register access moving
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((samples_ch.valid && samples_ch.ready) || (results_ch.valid && results_ch.ready)
          || psel)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no progress for %0d cycles, %0d periods still owed",
                 IDLE_LIMIT, periods_owed);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    int ph;
    int phase_start_periods;
    rst              <= 1'b1;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    samples_ch.valid <= 1'b0;
    samples_ch.level <= 1'b0;
    hold_req     = 1'b0;
    burst_left   = 0;
    sample_total = 0;
    phase_items  = 0;
    cur_level    = 1'b0;

    rate_plan[0] = 32'd1;              // slowest tick, frequency always zero
    rate_plan[1] = 32'd100000000;      // top of the specified range
    rate_plan[2] = 32'hFFFF_FFFF;      // all bits set, upper bits fall away
    rate_plan[3] = DATA_W'(RATE_RESET);
    rate_plan[4] = $urandom_range(2, 5000);
    rate_plan[5] = $urandom_range(1, 100000000);
    rate_plan[6] = $urandom_range(1, 100000000);
    rate_plan[7] = $urandom_range(1, 100000000);

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset value of the tick rate
    apb_access(APB_READ, TICK_RATE_ADDR, '0);

    // directed part at the reset tick rate
    // first sample high opens a measurement, shortest period of two ticks
    send_run(1'b1, 1);
    send_run(1'b0, 1);
    send_run(1'b1, 1);
    // high of two, low of one
    send_run(1'b0, 1);
    send_run(1'b1, 2);
    send_run(1'b0, 1);
    send_run(1'b1, 1);
    // more highs after the closing edge must not reopen
    send_run(1'b1, 2);
    send_run(1'b0, 2);
    send_run(1'b1, 1);
    send_run(1'b0, 3);
    send_run(1'b1, 1);
    // high-heavy period
    send_run(1'b0, 1);
    send_run(1'b1, 5);
    send_run(1'b0, 1);
    send_run(1'b1, 1);
    drain();

    for (ph = 0; ph < N_PHASES; ph++) begin
      // writes to the unused index leave the tick rate alone
      if (ph % 3 == 0) apb_access(APB_WRITE, UNMAPPED_ADDR, $urandom());
      apb_access(APB_WRITE, TICK_RATE_ADDR, rate_plan[ph]);
      apb_access(APB_READ, TICK_RATE_ADDR, '0);
      if (ph == PRESSURE_PHASE) hold_req = 1'b1;
      phase_items = 0;
      phase_start_periods = periods_predicted;
      while (phase_items < PHASE_ITEMS ||
             periods_predicted - phase_start_periods < PHASE_PERIODS) begin
        if ($urandom_range(0, 99) < 80) begin
          // well-formed: alternate levels with random run lengths
          send_run(~cur_level, pick_run_length());
        end else begin
          // noise: independent random levels, many one-tick runs
          repeat ($urandom_range(4, 24)) push_level(1'($urandom_range(0, 1)));
        end
      end
      drain();
    end

    $display("covered %0d samples and %0d measured periods over %0d tick-rate settings",
             sample_total, periods_predicted, N_PHASES + 1);
    $display("included a %0d-cycle result hold-off and full drains between settings",
             HOLD_CYCLES);
    if (mismatch_count == 0 && periods_owed == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
